// File: rtl/jrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jrc_pkg;

  // Decoding and calibration constants
  localparam logic [7:0] DEC_KEY      = 8'h17;
  localparam logic [7:0] CENTER_RESET = 8'd122;
  localparam logic [2:0] FULL_COUNT   = 3'd6;
  localparam int         BTN_C_BIT    = 1;
  localparam int         BTN_Z_BIT    = 0;

  // Percent scale and divider quotient width (quotient stays below 128)
  localparam logic signed [7:0] PCT_FULL = 8'sd100;
  localparam int                QUO_BITS = 7;
  localparam int                NUM_BITS = 15;

  // Calibration mode register codes
  typedef enum logic [1:0] {
    CAL_NORMAL = 2'd0,
    CAL_CENTER = 2'd1,
    CAL_RANGE  = 2'd2,
    CAL_BOTH   = 2'd3
  } cal_mode_t;

  // One raw controller report
  typedef struct packed {
    logic [7:0] raw_b0;
    logic [7:0] raw_b1;
    logic [7:0] raw_b2;
    logic [7:0] raw_b3;
    logic [7:0] raw_b4;
    logic [7:0] raw_b5;
    logic [2:0] byte_count;
  } in_item_t;

  // One decoded and calibrated result
  typedef struct packed {
    logic              report_ok;
    logic [7:0]        joy_x;
    logic [7:0]        joy_y;
    logic [9:0]        accel_x;
    logic [9:0]        accel_y;
    logic [9:0]        accel_z;
    logic              c_pressed;
    logic              z_pressed;
    logic signed [7:0] pct_x;
    logic signed [7:0] pct_y;
    logic              cal_done;
  } out_item_t;

  // Per-axis division job: numerator is deflection*100
  typedef struct packed {
    logic                zero;
    logic                neg;
    logic                sat;
    logic [NUM_BITS-1:0] num;
    logic [7:0]          span;
  } axis_job_t;

  // Queue entry between front and back
  typedef struct packed {
    logic       report_ok;
    logic [7:0] joy_x;
    logic [7:0] joy_y;
    logic [9:0] accel_x;
    logic [9:0] accel_y;
    logic [9:0] accel_z;
    logic       c_pressed;
    logic       z_pressed;
    logic       cal_done;
    axis_job_t  ax_x;
    axis_job_t  ax_y;
  } job_t;

endpackage

`default_nettype wire

// File: rtl/jrc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module jrc_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  jrc_pkg::in_item_t in_data,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [1:0]         cfg_data,
  output logic              push_valid,
  input  wire               push_ready,
  output jrc_pkg::job_t     push_data
);
  import jrc_pkg::*;

  typedef enum logic [3:0] {
    PH_CENTER_START = 4'b0001,
    PH_CENTER_CAP   = 4'b0010,
    PH_RANGE_ARM    = 4'b0100,
    PH_RANGE_CAP    = 4'b1000
  } cal_phase_t;

  function automatic logic [7:0] dec_byte(input logic [7:0] b);
    return (b ^ DEC_KEY) + DEC_KEY;
  endfunction

  function automatic axis_job_t axis_job(input logic [7:0] j, input logic [7:0] c,
                                         input logic [7:0] mn, input logic [7:0] mx);
    axis_job_t  a;
    logic [7:0] diff;
    logic [7:0] span;
    logic       span_ok;
    a = '0;
    if (j < c) begin
      diff    = c - j;
      span    = c - mn;
      span_ok = c > mn;
      a.neg   = 1'b1;
    end else begin
      diff    = j - c;
      span    = mx - c;
      span_ok = mx > c;
    end
    a.zero = (j == c);
    // deflection at or past the bound also lands on full scale
    a.sat  = !span_ok || (diff >= span);
    a.num  = (NUM_BITS'(diff) << 6) + (NUM_BITS'(diff) << 5) + (NUM_BITS'(diff) << 2);
    a.span = span;
    return a;
  endfunction

  cal_mode_t  mode_r, mode_nxt;
  cal_phase_t phase_r, phase_nxt;
  logic       fin_r, fin_nxt;
  logic       pend_r, pend_nxt;
  logic       ok_r, ok_nxt;
  logic [7:0] joy_x_r, joy_x_nxt, joy_y_r, joy_y_nxt;
  logic [9:0] acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt, acc_z_r, acc_z_nxt;
  logic       c_r, c_nxt, z_r, z_nxt;
  logic [7:0] cen_x_r, cen_x_nxt, cen_y_r, cen_y_nxt;
  logic [7:0] min_x_r, min_x_nxt, min_y_r, min_y_nxt;
  logic [7:0] max_x_r, max_x_nxt, max_y_r, max_y_nxt;

  logic       in_acc;
  logic       full;
  logic       center_done;
  logic [7:0] b5;

  assign in_ready   = !pend_r;
  assign cfg_ready  = 1'b1;
  assign push_valid = pend_r;
  assign in_acc     = in_valid && in_ready;
  assign full       = in_data.byte_count >= FULL_COUNT;
  assign b5         = dec_byte(in_data.raw_b5);

  // Decode, hold and calibrate on each accepted report
  always_comb begin
    mode_nxt    = mode_r;
    phase_nxt   = phase_r;
    fin_nxt     = fin_r;
    pend_nxt    = pend_r;
    ok_nxt      = ok_r;
    joy_x_nxt   = joy_x_r;
    joy_y_nxt   = joy_y_r;
    acc_x_nxt   = acc_x_r;
    acc_y_nxt   = acc_y_r;
    acc_z_nxt   = acc_z_r;
    c_nxt       = c_r;
    z_nxt       = z_r;
    cen_x_nxt   = cen_x_r;
    cen_y_nxt   = cen_y_r;
    min_x_nxt   = min_x_r;
    min_y_nxt   = min_y_r;
    max_x_nxt   = max_x_r;
    max_y_nxt   = max_y_r;
    center_done = 1'b0;

    if (push_valid && push_ready) begin
      pend_nxt = 1'b0;
    end

    if (in_acc) begin
      pend_nxt = 1'b1;
      ok_nxt   = full;
      if (full) begin
        joy_x_nxt = dec_byte(in_data.raw_b0);
        joy_y_nxt = dec_byte(in_data.raw_b1);
        acc_x_nxt = {dec_byte(in_data.raw_b2), b5[3:2]};
        acc_y_nxt = {dec_byte(in_data.raw_b3), b5[5:4]};
        acc_z_nxt = {dec_byte(in_data.raw_b4), b5[7:6]};
        c_nxt     = !b5[BTN_C_BIT];
        z_nxt     = !b5[BTN_Z_BIT];
      end
      if (mode_r != CAL_NORMAL && !fin_r) begin
        case (phase_r)
          PH_CENTER_START: begin
            if (c_nxt) center_done = 1'b1;
            else       phase_nxt   = PH_CENTER_CAP;
          end
          PH_CENTER_CAP: begin
            cen_x_nxt = joy_x_nxt;
            cen_y_nxt = joy_y_nxt;
            if (c_nxt) center_done = 1'b1;
          end
          PH_RANGE_ARM: begin
            if (!c_nxt) phase_nxt = PH_RANGE_CAP;
          end
          PH_RANGE_CAP: begin
            if (joy_x_nxt > max_x_r) max_x_nxt = joy_x_nxt;
            if (joy_x_nxt < min_x_r) min_x_nxt = joy_x_nxt;
            if (joy_y_nxt > max_y_r) max_y_nxt = joy_y_nxt;
            if (joy_y_nxt < min_y_r) min_y_nxt = joy_y_nxt;
            if (c_nxt) fin_nxt = 1'b1;
          end
          default: phase_nxt = PH_CENTER_START;
        endcase
        if (center_done) begin
          if (mode_r == CAL_BOTH) phase_nxt = PH_RANGE_ARM;
          else                    fin_nxt   = 1'b1;
        end
      end
    end

    // Mode write restarts calibration
    if (cfg_valid && cfg_ready) begin
      mode_nxt  = cal_mode_t'(cfg_data);
      fin_nxt   = 1'b0;
      phase_nxt = (cal_mode_t'(cfg_data) == CAL_RANGE) ? PH_RANGE_ARM : PH_CENTER_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= CAL_NORMAL;
      phase_r <= PH_CENTER_START;
      fin_r   <= 1'b0;
      pend_r  <= 1'b0;
      ok_r    <= 1'b0;
      joy_x_r <= '0;
      joy_y_r <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_z_r <= '0;
      c_r     <= 1'b0;
      z_r     <= 1'b0;
      cen_x_r <= CENTER_RESET;
      cen_y_r <= CENTER_RESET;
      min_x_r <= CENTER_RESET;
      min_y_r <= CENTER_RESET;
      max_x_r <= CENTER_RESET;
      max_y_r <= CENTER_RESET;
    end else begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      fin_r   <= fin_nxt;
      pend_r  <= pend_nxt;
      ok_r    <= ok_nxt;
      joy_x_r <= joy_x_nxt;
      joy_y_r <= joy_y_nxt;
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
      acc_z_r <= acc_z_nxt;
      c_r     <= c_nxt;
      z_r     <= z_nxt;
      cen_x_r <= cen_x_nxt;
      cen_y_r <= cen_y_nxt;
      min_x_r <= min_x_nxt;
      min_y_r <= min_y_nxt;
      max_x_r <= max_x_nxt;
      max_y_r <= max_y_nxt;
    end
  end

  // Classify each axis from the updated state
  always_comb begin
    push_data           = '0;
    push_data.report_ok = ok_r;
    push_data.joy_x     = joy_x_r;
    push_data.joy_y     = joy_y_r;
    push_data.accel_x   = acc_x_r;
    push_data.accel_y   = acc_y_r;
    push_data.accel_z   = acc_z_r;
    push_data.c_pressed = c_r;
    push_data.z_pressed = z_r;
    push_data.cal_done  = fin_r;
    push_data.ax_x      = axis_job(joy_x_r, cen_x_r, min_x_r, max_x_r);
    push_data.ax_y      = axis_job(joy_y_r, cen_y_r, min_y_r, max_y_r);
  end

  // Calibration can only finish while a capture mode is active
  a_fin_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fin_r) |-> $past(mode_r) != CAL_NORMAL)
    else $error("calibration finished in normal mode");

  // Range bounds never cross the reset center from the wrong side
  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    (min_x_r <= max_x_r) && (min_y_r <= max_y_r))
    else $error("range bounds inverted");

  // A new report is only taken once the previous one is queued
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !push_ready) |=> pend_r && $stable(ok_r))
    else $error("pending report lost");

endmodule

`default_nettype wire

// File: rtl/jrc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module jrc_queue #(
  parameter int DEPTH = 2
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push_valid,
  output logic           push_ready,
  input  jrc_pkg::job_t  push_data,
  output logic           pop_valid,
  input  wire            pop_ready,
  output jrc_pkg::job_t  pop_data
);
  import jrc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = cnt_r != CW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue occupancy out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with empty count");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed a request");

endmodule

`default_nettype wire

// File: rtl/jrc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module jrc_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                pop_valid,
  output logic               pop_ready,
  input  jrc_pkg::job_t      pop_data,
  output logic               out_valid,
  input  wire                out_ready,
  output jrc_pkg::out_item_t out_data
);
  import jrc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } bk_state_t;

  localparam int SW = $clog2(QUO_BITS);

  function automatic logic signed [7:0] axis_pct(input axis_job_t a,
                                                  input logic [QUO_BITS-1:0] q);
    logic signed [7:0] mag;
    mag = a.sat ? PCT_FULL : $signed(8'(q));
    if (a.zero)     return '0;
    else if (a.neg) return -mag;
    else            return mag;
  endfunction

  bk_state_t             state_r, state_nxt;
  job_t                  job_r, job_nxt;
  logic                  axis_r, axis_nxt;
  logic [SW-1:0]         step_r, step_nxt;
  logic [NUM_BITS-1:0]   rem_r, rem_nxt;
  logic [QUO_BITS-1:0]   quo_r, quo_nxt;
  logic signed [7:0]     pctx_r, pctx_nxt;
  logic signed [7:0]     pcty_r, pcty_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  axis_job_t             cur;
  logic [NUM_BITS-1:0]   trial;
  logic                  fits;
  logic [QUO_BITS-1:0]   quo_cur;
  logic [NUM_BITS-1:0]   rem_cur;
  logic signed [7:0]     pct_cur;

  assign pop_ready = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // One restoring step of the shared divider
  assign cur     = axis_r ? job_r.ax_y : job_r.ax_x;
  assign trial   = NUM_BITS'(cur.span) << step_r;
  assign fits    = rem_r >= trial;
  assign rem_cur = fits ? rem_r - trial : rem_r;
  assign quo_cur = quo_r | (QUO_BITS'(fits) << step_r);
  assign pct_cur = axis_pct(cur, quo_cur);

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    axis_nxt      = axis_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    pctx_nxt      = pctx_r;
    pcty_nxt      = pcty_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          job_nxt   = pop_data;
          axis_nxt  = 1'b0;
          step_nxt  = SW'(QUO_BITS - 1);
          rem_nxt   = pop_data.ax_x.num;
          quo_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = rem_cur;
        quo_nxt  = quo_cur;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          if (!axis_r) begin
            // X done, start Y
            pctx_nxt = pct_cur;
            axis_nxt = 1'b1;
            step_nxt = SW'(QUO_BITS - 1);
            rem_nxt  = job_r.ax_y.num;
            quo_nxt  = '0;
          end else begin
            pcty_nxt  = pct_cur;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        // Load the output register once it is free or being drained
        if (!out_valid_r || out_ready) begin
          out_data_nxt.report_ok = job_r.report_ok;
          out_data_nxt.joy_x     = job_r.joy_x;
          out_data_nxt.joy_y     = job_r.joy_y;
          out_data_nxt.accel_x   = job_r.accel_x;
          out_data_nxt.accel_y   = job_r.accel_y;
          out_data_nxt.accel_z   = job_r.accel_z;
          out_data_nxt.c_pressed = job_r.c_pressed;
          out_data_nxt.z_pressed = job_r.z_pressed;
          out_data_nxt.cal_done  = job_r.cal_done;
          out_data_nxt.pct_x     = pctx_r;
          out_data_nxt.pct_y     = pcty_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    axis_r     <= axis_nxt;
    step_r     <= step_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    pctx_r     <= pctx_nxt;
    pcty_r     <= pcty_nxt;
    out_data_r <= out_data_nxt;
  end

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.pct_x >= -PCT_FULL) && (out_data_r.pct_x <= PCT_FULL)
                 && (out_data_r.pct_y >= -PCT_FULL) && (out_data_r.pct_y <= PCT_FULL))
    else $error("percent outside full scale");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result shown without a finished division");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !cur.sat) |-> rem_r < (NUM_BITS'(cur.span) << (step_r + 1'b1)))
    else $error("divider remainder out of range");

endmodule

`default_nettype wire

// File: rtl/joystick_report_calibrator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in_      input      in_valid / in_ready        in_data  (raw report, byte count)
// out_     output     out_valid / out_ready      out_data (decoded values, percents)
// cfg_     input      cfg_valid / cfg_ready      cfg_data (calibration mode)
//
// After a report is accepted, the accepting edge registers decode and
// calibration; the report is then queued, popped by the back, divided in the
// shared restoring divider (7 quotient bits per axis, X then Y) and loaded
// into the output register. The back pops a new report only once it is idle
// again; the front takes the next report while the back runs and the queue has room.
// Reset is synchronous and active low; cfg_ready is always high.
// A waiting result stalls the back; the queue keeps the front moving until it fills.

module joystick_report_calibrator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  jrc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output jrc_pkg::out_item_t out_data,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [1:0]          cfg_data
);
  import jrc_pkg::*;

  logic push_valid, push_ready;
  job_t push_data;
  logic pop_valid, pop_ready;
  job_t pop_data;

  jrc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  jrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  jrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: sim/tb_joystick_report_calibrator.sv
`timescale 1ns / 1ps

module tb_joystick_report_calibrator;
  import jrc_pkg::*;

  localparam int TARGET_REPORTS = 1850;
  localparam int QUIET_LIMIT    = 1000;
  localparam int DRAIN_CYCLES   = 40;

  // Calibration progress as tracked by the predictor
  typedef enum logic [1:0] {
    SEEK_CENTER  = 2'd0,
    TRACK_CENTER = 2'd1,
    ARM_RANGE    = 2'd2,
    TRACK_RANGE  = 2'd3
  } cal_step_t;

  // One pending request for the driver: a report or a mode write
  typedef struct packed {
    logic      is_mode;
    cal_mode_t mode;
    in_item_t  rpt;
  } stim_entry_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      cfg_valid = 1'b0;
  logic [1:0] cfg_data = 2'd0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;
  logic      cfg_ready;

  stim_entry_t pending_q[$];
  out_item_t   calibrated_q[$];

  int reports_queued = 0;
  int reports_sent   = 0;
  int short_reports  = 0;
  int mode_writes    = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  // Predictor state
  cal_mode_t  cur_mode;
  cal_step_t  cal_step;
  logic       cal_complete;
  logic [7:0] held_joy[2];
  logic [9:0] held_accel[3];
  logic       held_c;
  logic       held_z;
  logic [7:0] joy_center[2];
  logic [7:0] joy_lo[2];
  logic [7:0] joy_hi[2];

  joystick_report_calibrator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] unscramble(logic [7:0] b);
    return (b ^ DEC_KEY) + DEC_KEY;
  endfunction

  // Inverse of the byte decode, used to build reports from wanted values
  function automatic logic [7:0] scramble(logic [7:0] d);
    return (d - DEC_KEY) ^ DEC_KEY;
  endfunction

  function automatic int deflection_pct(int j, int c, int lo, int hi);
    int span;
    int t;
    if (j < c) begin
      span = c - lo;
      if (span <= 0) return -100;
      t = (c - j) * 100 / span;
      return (t > 100) ? -100 : -t;
    end
    if (j > c) begin
      span = hi - c;
      if (span <= 0) return 100;
      t = (j - c) * 100 / span;
      return (t > 100) ? 100 : t;
    end
    return 0;
  endfunction

  task automatic reset_predictor();
    cur_mode     = CAL_NORMAL;
    cal_step     = SEEK_CENTER;
    cal_complete = 1'b0;
    held_c       = 1'b0;
    held_z       = 1'b0;
    for (int k = 0; k < 2; k++) begin
      held_joy[k]   = '0;
      joy_center[k] = CENTER_RESET;
      joy_lo[k]     = CENTER_RESET;
      joy_hi[k]     = CENTER_RESET;
    end
    for (int k = 0; k < 3; k++) held_accel[k] = '0;
  endtask

  // A mode write restarts calibration
  task automatic apply_mode(cal_mode_t m);
    cur_mode     = m;
    cal_complete = 1'b0;
    cal_step     = (m == CAL_RANGE) ? ARM_RANGE : SEEK_CENTER;
  endtask

  function automatic out_item_t calibrate_report(in_item_t rpt);
    out_item_t  res;
    logic [7:0] b5;
    logic       full;
    logic       center_done;
    full        = (rpt.byte_count >= FULL_COUNT);
    center_done = 1'b0;

    // Decode; a short report keeps every held value
    if (full) begin
      b5            = unscramble(rpt.raw_b5);
      held_joy[0]   = unscramble(rpt.raw_b0);
      held_joy[1]   = unscramble(rpt.raw_b1);
      held_accel[0] = {unscramble(rpt.raw_b2), b5[3:2]};
      held_accel[1] = {unscramble(rpt.raw_b3), b5[5:4]};
      held_accel[2] = {unscramble(rpt.raw_b4), b5[7:6]};
      held_c        = ~b5[BTN_C_BIT];
      held_z        = ~b5[BTN_Z_BIT];
    end

    // Calibration steps on held values
    if (cur_mode != CAL_NORMAL && !cal_complete) begin
      case (cal_step)
        SEEK_CENTER: begin
          if (held_c) center_done = 1'b1;
          else cal_step = TRACK_CENTER;
        end
        TRACK_CENTER: begin
          joy_center[0] = held_joy[0];
          joy_center[1] = held_joy[1];
          if (held_c) center_done = 1'b1;
        end
        ARM_RANGE: begin
          if (!held_c) cal_step = TRACK_RANGE;
        end
        default: begin
          for (int k = 0; k < 2; k++) begin
            if (held_joy[k] > joy_hi[k]) joy_hi[k] = held_joy[k];
            if (held_joy[k] < joy_lo[k]) joy_lo[k] = held_joy[k];
          end
          if (held_c) cal_complete = 1'b1;
        end
      endcase
      if (center_done) begin
        if (cur_mode == CAL_BOTH) cal_step = ARM_RANGE;
        else cal_complete = 1'b1;
      end
    end

    res.report_ok = full;
    res.joy_x     = held_joy[0];
    res.joy_y     = held_joy[1];
    res.accel_x   = held_accel[0];
    res.accel_y   = held_accel[1];
    res.accel_z   = held_accel[2];
    res.c_pressed = held_c;
    res.z_pressed = held_z;
    res.pct_x     = 8'(deflection_pct(held_joy[0], joy_center[0], joy_lo[0], joy_hi[0]));
    res.pct_y     = 8'(deflection_pct(held_joy[1], joy_center[1], joy_lo[1], joy_hi[1]));
    res.cal_done  = cal_complete;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  task automatic add_raw(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3,
                         logic [7:0] b4, logic [7:0] b5, logic [2:0] cnt);
    stim_entry_t e;
    e.is_mode        = 1'b0;
    e.mode           = CAL_NORMAL;
    e.rpt.raw_b0     = b0;
    e.rpt.raw_b1     = b1;
    e.rpt.raw_b2     = b2;
    e.rpt.raw_b3     = b3;
    e.rpt.raw_b4     = b4;
    e.rpt.raw_b5     = b5;
    e.rpt.byte_count = cnt;
    pending_q.push_back(e);
    reports_queued++;
  endtask

  // Build a report from decoded values; buttons are given as pressed flags
  task automatic add_report(logic [7:0] jx, logic [7:0] jy, logic [9:0] ax, logic [9:0] ay,
                            logic [9:0] az, logic c, logic z, logic [2:0] cnt);
    logic [7:0] b5;
    b5 = {az[1:0], ay[1:0], ax[1:0], ~c, ~z};
    add_raw(scramble(jx), scramble(jy), scramble(ax[9:2]), scramble(ay[9:2]),
            scramble(az[9:2]), scramble(b5), cnt);
  endtask

  task automatic add_mode(cal_mode_t m);
    stim_entry_t e;
    e         = '0;
    e.is_mode = 1'b1;
    e.mode    = m;
    pending_q.push_back(e);
  endtask

  function automatic logic [7:0] pick_joy();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r <= 4) return 8'(int'(CENTER_RESET) + $urandom_range(0, 20) - 10);
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [2:0] pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 3'($urandom_range(0, 5));
    if (r == 2) return 3'd7;
    return FULL_COUNT;
  endfunction

  // Mostly shaped reports with the requested C state, some raw noise
  task automatic add_shaped(logic c);
    if ($urandom_range(0, 9) == 0) begin
      add_raw(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 3'($urandom_range(0, 7)));
    end else begin
      add_report(pick_joy(), pick_joy(), 10'($urandom), 10'($urandom), 10'($urandom),
                 c, 1'($urandom), pick_count());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: sends requests in bursts, writes the mode only when drained
  // ---------------------------------------------------------------------------

  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : report_driver
    logic        in_fire;
    logic        cfg_fire;
    logic        nxt_in_valid;
    logic        nxt_cfg_valid;
    in_item_t    nxt_in_data;
    logic [1:0]  nxt_cfg_data;
    stim_entry_t head;
    if (!rst_n) begin
      reset_predictor();
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      in_fire  = in_valid && in_ready;
      cfg_fire = cfg_valid && cfg_ready;
      if (in_fire) begin
        calibrated_q.push_back(calibrate_report(in_data));
        reports_sent++;
        if (in_data.byte_count < FULL_COUNT) short_reports++;
      end
      if (cfg_fire) begin
        apply_mode(cal_mode_t'(cfg_data));
        mode_writes++;
      end

      nxt_in_valid  = in_valid && !in_fire;
      nxt_cfg_valid = cfg_valid && !cfg_fire;
      nxt_in_data   = in_data;
      nxt_cfg_data  = cfg_data;

      if (!nxt_in_valid && !nxt_cfg_valid && pending_q.size() != 0) begin
        head = pending_q[0];
        if (head.is_mode) begin
          // Mode write only once every result is back
          if (calibrated_q.size() == 0 && !in_valid) begin
            nxt_cfg_valid = 1'b1;
            nxt_cfg_data  = head.mode;
            void'(pending_q.pop_front());
          end
        end else if (gap_left != 0) begin
          gap_left--;
        end else begin
          nxt_in_valid = 1'b1;
          nxt_in_data  = head.rpt;
          void'(pending_q.pop_front());
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end

      in_valid  <= nxt_in_valid;
      in_data   <= nxt_in_data;
      cfg_valid <= nxt_cfg_valid;
      cfg_data  <= nxt_cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares results, stalls the result channel on its own pattern
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  int stall_left = 0;
  int free_left  = 0;

  always @(posedge clk) begin : result_monitor
    out_item_t want;
    logic      rdy;
    int        r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (calibrated_q.size() == 0) begin
          $error("result with no report outstanding");
          mismatches++;
        end else begin
          want = calibrated_q.pop_front();
          check_field("report_ok", want.report_ok, out_data.report_ok);
          check_field("joy_x", want.joy_x, out_data.joy_x);
          check_field("joy_y", want.joy_y, out_data.joy_y);
          check_field("accel_x", want.accel_x, out_data.accel_x);
          check_field("accel_y", want.accel_y, out_data.accel_y);
          check_field("accel_z", want.accel_z, out_data.accel_z);
          check_field("c_pressed", want.c_pressed, out_data.c_pressed);
          check_field("z_pressed", want.z_pressed, out_data.z_pressed);
          check_field("pct_x", $signed(want.pct_x), $signed(out_data.pct_x));
          check_field("pct_y", $signed(want.pct_y), $signed(out_data.pct_y));
          check_field("cal_done", want.cal_done, out_data.cal_done);
        end
      end

      // Ready pattern: long free runs, short blips, long stalls
      if (stall_left != 0) begin
        rdy = 1'b0;
        stall_left--;
      end else if (free_left != 0) begin
        rdy = 1'b1;
        free_left--;
      end else begin
        r = $urandom_range(0, 3);
        case (r)
          0: free_left = $urandom_range(20, 150);
          1: stall_left = $urandom_range(1, 3);
          2: stall_left = $urandom_range(10, 40);
          default: free_left = $urandom_range(0, 4);
        endcase
        rdy = (r == 0 || r == 3);
      end
      out_ready <= rdy;
    end
  end

  // Cycles with no handshake on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Stuck: no handshake for %0d cycles", QUIET_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin : test_sequence
    cal_mode_t seg_mode;
    int        n;

    // Normal mode straight out of reset: extremes and short reports
    add_raw(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, FULL_COUNT);
    add_raw(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, FULL_COUNT);
    add_report(8'd122, 8'd122, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, FULL_COUNT);
    add_report(8'd255, 8'd0, 10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b1, FULL_COUNT);
    add_raw(8'h5A, 8'hA5, 8'h3C, 8'hC3, 8'h0F, 8'hF0, 3'd0);
    add_raw(8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 3'd5);
    add_report(8'd10, 8'd250, 10'd512, 10'd1, 10'd1022, 1'b0, 1'b1, 3'd7);

    // Center capture, then inverted spans against the reset range
    add_mode(CAL_CENTER);
    add_report(8'd140, 8'd100, 10'd300, 10'd400, 10'd500, 1'b0, 1'b0, FULL_COUNT);
    add_report(8'd130, 8'd110, 10'd301, 10'd401, 10'd501, 1'b0, 1'b0, FULL_COUNT);
    add_report(8'd128, 8'd120, 10'd302, 10'd402, 10'd502, 1'b1, 1'b0, FULL_COUNT);
    add_report(8'd200, 8'd50, 10'd303, 10'd403, 10'd503, 1'b0, 1'b0, FULL_COUNT);

    // Range capture: armed while C held, widened to both extremes
    add_mode(CAL_RANGE);
    add_report(8'd128, 8'd120, 10'd10, 10'd20, 10'd30, 1'b1, 1'b0, FULL_COUNT);
    add_raw(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd3);
    add_report(8'd0, 8'd255, 10'd11, 10'd21, 10'd31, 1'b0, 1'b0, FULL_COUNT);
    add_report(8'd0, 8'd255, 10'd12, 10'd22, 10'd32, 1'b0, 1'b1, FULL_COUNT);
    add_report(8'd255, 8'd0, 10'd13, 10'd23, 10'd33, 1'b0, 1'b0, FULL_COUNT);
    add_report(8'd64, 8'd200, 10'd14, 10'd24, 10'd34, 1'b1, 1'b0, FULL_COUNT);
    add_report(8'd192, 8'd60, 10'd15, 10'd25, 10'd35, 1'b0, 1'b0, FULL_COUNT);

    // Both: C already held at the start skips straight to arming
    add_mode(CAL_BOTH);
    add_report(8'd122, 8'd122, 10'd700, 10'd800, 10'd900, 1'b1, 1'b0, FULL_COUNT);
    add_report(8'd100, 8'd100, 10'd701, 10'd801, 10'd901, 1'b0, 1'b0, FULL_COUNT);
    add_report(8'd30, 8'd220, 10'd702, 10'd802, 10'd902, 1'b1, 1'b1, FULL_COUNT);
    add_report(8'd127, 8'd119, 10'd703, 10'd803, 10'd903, 1'b0, 1'b0, FULL_COUNT);

    add_mode(CAL_NORMAL);
    add_report(8'd128, 8'd120, 10'd704, 10'd804, 10'd904, 1'b0, 1'b1, FULL_COUNT);
    add_report(8'd129, 8'd121, 10'd705, 10'd805, 10'd905, 1'b0, 1'b0, FULL_COUNT);

    // Random segments: a mode write followed by a calibration-shaped sequence
    while (reports_queued < TARGET_REPORTS) begin
      seg_mode = cal_mode_t'($urandom_range(0, 3));
      add_mode(seg_mode);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) add_shaped(1'b0);
      add_shaped(1'b1);
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) add_shaped(1'b0);
      n = $urandom_range(2, 10);
      for (int i = 0; i < n; i++) add_shaped(1'b0);
      add_shaped(1'b1);
      n = $urandom_range(5, 40);
      for (int i = 0; i < n; i++) add_shaped(($urandom_range(0, 4) == 0));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid || cfg_valid || calibrated_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d reports (%0d short) across %0d mode writes; %0d results checked.",
             reports_sent, short_reports, mode_writes, results_seen);
    if (mismatches == 0 && calibrated_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
